### rtl/scmc_pkg.sv
package scmc_pkg;

  localparam int MAG_ENTRIES_D  = 127;
  localparam int SIZE_CLASSES_D = 6;
  localparam int DEPOT_DEPTH_D  = 4;
  localparam int PFN_BITS_D     = 52;

  localparam int PAGES_W = 16;
  localparam int FIELD_W = 52;
  localparam int CLS_W   = 5;

  localparam logic FUNC_GET    = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  // ceiling log2 of the page count, zero pages map to class 0
  function automatic logic [CLS_W-1:0] size_class(input logic [PAGES_W-1:0] pages);
    logic [PAGES_W-1:0] m;
    logic [CLS_W-1:0]   c;
    m = pages - PAGES_W'(1);
    c = '0;
    if (pages > PAGES_W'(1)) begin
      for (int b = 0; b < PAGES_W; b++) begin
        if (m[b]) begin
          c = CLS_W'(b + 1);
        end
      end
    end
    return c;
  endfunction

endpackage

### rtl/size_class_magazine_cache_core.sv
// Per-CPU cache of freed page-frame ranges sorted by size class (ceiling log2 of the
// page count). Pulse start with busy low to hand in one beat; exactly one result
// beat follows, marked by done_o for a single cycle, and it must be taken then since
// the receiver cannot stall. A rejected or out-of-class request is answered from idle;
// an insert passes FLD, FPV and DEC; a get with a nonempty magazine adds SCAN and,
// on a hit, MVRD and MVWR. The scan reads one magazine entry per cycle from the
// simple dual-port store memory and checks it against the limit in one comparator.
module size_class_magazine_cache_core
  import scmc_pkg::*;
#(
  parameter int MAG_ENTRIES  = MAG_ENTRIES_D,
  parameter int SIZE_CLASSES = SIZE_CLASSES_D,
  parameter int DEPOT_DEPTH  = DEPOT_DEPTH_D,
  parameter int PFN_BITS     = PFN_BITS_D
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               func_i,
  input  logic [PAGES_W-1:0] pages_i,
  input  logic [FIELD_W-1:0] start_pfn_i,
  input  logic [FIELD_W-1:0] limit_excl_i,
  output logic               done_o,
  output logic               ok_o,
  output logic [FIELD_W-1:0] found_pfn_o
);

  localparam int SLOTS  = DEPOT_DEPTH + 2;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CW     = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
  localparam int FW     = $clog2(MAG_ENTRIES + 1);
  localparam int DCW    = $clog2(DEPOT_DEPTH + 1);
  localparam int DIW    = (DEPOT_DEPTH > 1) ? $clog2(DEPOT_DEPTH) : 1;
  localparam int FDEPTH = SIZE_CLASSES * SLOTS;
  localparam int FAW    = $clog2(FDEPTH);
  localparam int SDEPTH = FDEPTH * MAG_ENTRIES;
  localparam int SAW    = $clog2(SDEPTH);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FLD  = 3'd1;
  localparam logic [2:0] ST_FPV  = 3'd2;
  localparam logic [2:0] ST_DEC  = 3'd3;
  localparam logic [2:0] ST_SCAN = 3'd4;
  localparam logic [2:0] ST_MVRD = 3'd5;
  localparam logic [2:0] ST_MVWR = 3'd6;

  logic [2:0]         state_q, state_d;
  logic               func_q;
  logic [CW-1:0]      cls_q;
  logic [FIELD_W-1:0] lim_q;
  logic [FIELD_W-1:0] pfn_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [FW-1:0]      n_q, fl_q, rd_cnt_q, cmp_idx_q, hit_idx_q;
  logic               cmp_vld_q, fv_q;
  logic               done_q, ok_q;
  logic [FIELD_W-1:0] found_q;

  logic [SLOT_W-1:0] ld_q   [SIZE_CLASSES];
  logic [SLOT_W-1:0] pv_q   [SIZE_CLASSES];
  logic [DCW-1:0]    dcnt_q [SIZE_CLASSES];
  logic [SLOTS-1:0]  used_q [SIZE_CLASSES];
  logic [SLOT_W-1:0] depot_q [SIZE_CLASSES][DEPOT_DEPTH];
  logic [FDEPTH-1:0] fvalid_q;

  logic              fill_we, fill_re;
  logic [FAW-1:0]    fill_waddr, fill_raddr;
  logic [FW-1:0]     fill_wdata, fill_rdata;
  logic              st_we, st_re;
  logic [SAW-1:0]    st_waddr, st_raddr;
  logic [PFN_BITS-1:0] st_wdata, st_rdata;

  logic [CLS_W-1:0]  in_cls;
  logic              accept;
  logic [SLOT_W-1:0] ld, pv, free_s, pop_s;
  logic [DCW-1:0]    dc;
  logic [FW-1:0]     fp;
  logic              dec_ok, dec_swap, dec_push, dec_pop;
  logic [SLOT_W-1:0] dec_slot;
  logic [FW-1:0]     dec_n;
  logic [63:0]       rd_wide, lim_wide;
  logic              rd_fits;

  function automatic logic [FAW-1:0] fbase(input logic [CW-1:0] c, input logic [SLOT_W-1:0] s);
    return FAW'(c) * FAW'(SLOTS) + FAW'(s);
  endfunction

  function automatic logic [SAW-1:0] saddr(input logic [CW-1:0] c, input logic [SLOT_W-1:0] s,
                                          input logic [FW-1:0] i);
    return SAW'(fbase(c, s)) * SAW'(MAG_ENTRIES) + SAW'(i);
  endfunction

  assign accept  = start && !busy;
  assign busy    = (state_q != ST_IDLE);
  assign in_cls  = size_class(pages_i);
  assign ld      = ld_q[cls_q];
  assign pv      = pv_q[cls_q];
  assign dc      = dcnt_q[cls_q];
  assign fp      = fv_q ? fill_rdata : '0;
  assign pop_s   = depot_q[cls_q][DIW'(dc - DCW'(1))];
  assign rd_wide  = 64'(st_rdata);
  assign lim_wide = 64'(lim_q);
  assign rd_fits  = (rd_wide <= lim_wide);

  always_comb begin
    free_s = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!used_q[cls_q][s]) begin
        free_s = SLOT_W'(s);
      end
    end
  end

  always_comb begin
    dec_ok   = 1'b1;
    dec_swap = 1'b0;
    dec_push = 1'b0;
    dec_pop  = 1'b0;
    dec_slot = ld;
    dec_n    = fl_q;
    if (func_q == FUNC_INSERT) begin
      if (fl_q < FW'(MAG_ENTRIES)) begin
        dec_slot = ld;
      end else if (fp < FW'(MAG_ENTRIES)) begin
        dec_swap = 1'b1;
        dec_slot = pv;
        dec_n    = fp;
      end else if (dc < DCW'(DEPOT_DEPTH)) begin
        dec_push = 1'b1;
        dec_slot = free_s;
        dec_n    = '0;
      end else begin
        dec_ok = 1'b0;
      end
    end else begin
      if (fl_q != '0) begin
        dec_slot = ld;
      end else if (fp != '0) begin
        dec_swap = 1'b1;
        dec_slot = pv;
        dec_n    = fp;
      end else if (dc != '0) begin
        dec_pop  = 1'b1;
        dec_slot = pop_s;
        dec_n    = FW'(MAG_ENTRIES);
      end else begin
        dec_ok = 1'b0;
      end
    end
  end

  always_comb begin
    fill_re    = 1'b0;
    fill_raddr = fbase(cls_q, ld);
    fill_we    = 1'b0;
    fill_waddr = fbase(cls_q, dec_slot);
    fill_wdata = dec_n + FW'(1);
    st_re      = 1'b0;
    st_raddr   = saddr(cls_q, slot_q, rd_cnt_q - FW'(1));
    st_we      = 1'b0;
    st_waddr   = saddr(cls_q, dec_slot, dec_n);
    st_wdata   = PFN_BITS'(pfn_q);
    case (state_q)
      ST_FLD: begin
        fill_re = 1'b1;
      end
      ST_FPV: begin
        fill_re    = 1'b1;
        fill_raddr = fbase(cls_q, pv);
      end
      ST_DEC: begin
        if (dec_ok && func_q == FUNC_INSERT) begin
          fill_we = 1'b1;
          st_we   = 1'b1;
        end
      end
      ST_SCAN: begin
        st_re = (rd_cnt_q != '0);
      end
      ST_MVRD: begin
        st_re    = 1'b1;
        st_raddr = saddr(cls_q, slot_q, n_q - FW'(1));
      end
      ST_MVWR: begin
        fill_we    = 1'b1;
        fill_waddr = fbase(cls_q, slot_q);
        fill_wdata = n_q - FW'(1);
        st_we      = 1'b1;
        st_waddr   = saddr(cls_q, slot_q, hit_idx_q);
        st_wdata   = st_rdata;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_cls >= CLS_W'(SIZE_CLASSES) ||
              (func_i == FUNC_GET && limit_excl_i < FIELD_W'(pages_i))) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_FLD;
          end
        end
      end
      ST_FLD:  state_d = ST_FPV;
      ST_FPV:  state_d = ST_DEC;
      ST_DEC: begin
        if (dec_ok && func_q == FUNC_GET) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (cmp_vld_q && rd_fits) begin
          state_d = ST_MVRD;
        end else if (cmp_vld_q && cmp_idx_q == '0) begin
          state_d = ST_IDLE;
        end
      end
      ST_MVRD: state_d = ST_MVWR;
      ST_MVWR: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      done_q   <= 1'b0;
      fvalid_q <= '0;
      for (int c = 0; c < SIZE_CLASSES; c++) begin
        ld_q[c]   <= SLOT_W'(0);
        pv_q[c]   <= SLOT_W'(1);
        dcnt_q[c] <= '0;
        used_q[c] <= SLOTS'(3);
      end
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (fill_we) begin
        fvalid_q[fill_waddr] <= 1'b1;
      end
      if (state_q == ST_IDLE && accept && state_d == ST_IDLE) begin
        done_q <= 1'b1;
      end
      if (state_q == ST_DEC) begin
        if (!dec_ok || func_q == FUNC_INSERT) begin
          done_q <= 1'b1;
        end
        if (dec_swap) begin
          ld_q[cls_q] <= pv;
          pv_q[cls_q] <= ld;
        end
        if (dec_push) begin
          dcnt_q[cls_q] <= dc + DCW'(1);
          ld_q[cls_q]   <= free_s;
          used_q[cls_q] <= used_q[cls_q] | (SLOTS'(1) << free_s);
        end
        if (dec_pop) begin
          dcnt_q[cls_q] <= dc - DCW'(1);
          ld_q[cls_q]   <= pop_s;
          used_q[cls_q] <= used_q[cls_q] & ~(SLOTS'(1) << ld);
        end
      end
      if (state_q == ST_SCAN && state_d == ST_IDLE) begin
        done_q <= 1'b1;
      end
      if (state_q == ST_MVWR) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DEC && dec_push) begin
      depot_q[cls_q][DIW'(dc)] <= ld;
    end
  end

  always_ff @(posedge clk_i) begin
    fv_q <= fvalid_q[fill_raddr];
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          func_q  <= func_i;
          cls_q   <= CW'(in_cls);
          lim_q   <= limit_excl_i - FIELD_W'(pages_i);
          pfn_q   <= start_pfn_i;
          ok_q    <= 1'b0;
          found_q <= '0;
        end
      end
      ST_FPV: begin
        fl_q <= fp;
      end
      ST_DEC: begin
        slot_q    <= dec_slot;
        n_q       <= dec_n;
        rd_cnt_q  <= dec_n;
        cmp_vld_q <= 1'b0;
        ok_q      <= dec_ok && func_q == FUNC_INSERT;
        found_q   <= '0;
      end
      ST_SCAN: begin
        if (cmp_vld_q && rd_fits) begin
          pfn_q     <= FIELD_W'(rd_wide);
          hit_idx_q <= cmp_idx_q;
        end else begin
          cmp_vld_q <= (rd_cnt_q != '0);
          cmp_idx_q <= rd_cnt_q - FW'(1);
          if (rd_cnt_q != '0) begin
            rd_cnt_q <= rd_cnt_q - FW'(1);
          end
        end
        ok_q    <= 1'b0;
        found_q <= '0;
      end
      ST_MVWR: begin
        ok_q    <= 1'b1;
        found_q <= pfn_q;
      end
      default: begin
      end
    endcase
  end

  scmc_ram #(
    .Width(FW),
    .Depth(FDEPTH)
  ) u_fill_ram (
    .clk_i  (clk_i),
    .we_i   (fill_we),
    .waddr_i(fill_waddr),
    .wdata_i(fill_wdata),
    .re_i   (fill_re),
    .raddr_i(fill_raddr),
    .rdata_o(fill_rdata)
  );

  scmc_ram #(
    .Width(PFN_BITS),
    .Depth(SDEPTH)
  ) u_store_ram (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .re_i   (st_re),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  assign done_o      = done_q;
  assign ok_o        = ok_q;
  assign found_pfn_o = found_q;

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy || done_o)
    else $error("accepted beat neither in work nor answered");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !ok_o |-> found_pfn_o == '0)
    else $error("miss carries a nonzero pfn");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN && cmp_vld_q |-> cmp_idx_q < n_q)
    else $error("scan index beyond magazine fill");

  a_depot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> dcnt_q[cls_q] <= DCW'(DEPOT_DEPTH))
    else $error("depot count overflow");

endmodule

### rtl/scmc_ram.sv
module scmc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### tb/size_class_magazine_cache_checker.sv
`timescale 1ns / 1ps

module size_class_magazine_cache_checker
  import scmc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic               func_i,
  input  logic [PAGES_W-1:0] pages_i,
  input  logic [FIELD_W-1:0] start_pfn_i,
  input  logic [FIELD_W-1:0] limit_excl_i,
  input  logic               done_i,
  input  logic               ok_i,
  input  logic [FIELD_W-1:0] found_pfn_i,
  output int                 mismatches_o,
  output int                 pending_o
);

  localparam int SLOTS = DEPOT_DEPTH_D + 2;

  typedef struct packed {
    logic               ok;
    logic [FIELD_W-1:0] pfn;
  } lookup_beat_t;

  logic [FIELD_W-1:0] mag_pfn [SIZE_CLASSES_D][SLOTS][MAG_ENTRIES_D];
  int unsigned        mag_fill [SIZE_CLASSES_D][SLOTS];
  int unsigned        cur_slot [SIZE_CLASSES_D];
  int unsigned        alt_slot [SIZE_CLASSES_D];
  int unsigned        depot [SIZE_CLASSES_D][DEPOT_DEPTH_D];
  int unsigned        depot_n [SIZE_CLASSES_D];
  lookup_beat_t       expected_beats [$];
  int                 mismatches;

  assign mismatches_o = mismatches;
  assign pending_o    = expected_beats.size();

  initial begin
    mismatches = 0;
    for (int c = 0; c < SIZE_CLASSES_D; c++) begin
      cur_slot[c] = 0;
      alt_slot[c] = 1;
      depot_n[c]  = 0;
      for (int s = 0; s < SLOTS; s++) mag_fill[c][s] = 0;
    end
  end

  function automatic int unsigned page_class(logic [PAGES_W-1:0] pages);
    int unsigned c;
    c = 0;
    while (c < 20 && (32'd1 << c) < pages) c++;
    return c;
  endfunction

  function automatic int unsigned spare_slot(int unsigned c);
    bit taken;
    for (int s = 0; s < SLOTS; s++) begin
      taken = (s == cur_slot[c]) || (s == alt_slot[c]);
      for (int d = 0; d < depot_n[c]; d++) if (depot[c][d] == s) taken = 1;
      if (!taken) return s;
    end
    return 0;
  endfunction

  function automatic bit cache_insert(int unsigned c, logic [FIELD_W-1:0] pfn);
    int unsigned ld, pv, ns;
    ld = cur_slot[c];
    pv = alt_slot[c];
    if (mag_fill[c][ld] >= MAG_ENTRIES_D) begin
      if (mag_fill[c][pv] < MAG_ENTRIES_D) begin
        cur_slot[c] = pv;
        alt_slot[c] = ld;
        ld = pv;
      end else if (depot_n[c] < DEPOT_DEPTH_D) begin
        ns = spare_slot(c);
        depot[c][depot_n[c]] = ld;
        depot_n[c]++;
        cur_slot[c] = ns;
        mag_fill[c][ns] = 0;
        ld = ns;
      end else begin
        return 0;
      end
    end
    mag_pfn[c][ld][mag_fill[c][ld]] = pfn;
    mag_fill[c][ld]++;
    return 1;
  endfunction

  function automatic bit cache_fetch(int unsigned c, logic [FIELD_W-1:0] lim,
                                     output logic [FIELD_W-1:0] pfn);
    int unsigned ld, pv, n;
    pfn = '0;
    ld = cur_slot[c];
    pv = alt_slot[c];
    if (mag_fill[c][ld] == 0) begin
      if (mag_fill[c][pv] != 0) begin
        cur_slot[c] = pv;
        alt_slot[c] = ld;
        ld = pv;
      end else if (depot_n[c] > 0) begin
        depot_n[c]--;
        ld = depot[c][depot_n[c]];
        cur_slot[c] = ld;
        mag_fill[c][ld] = MAG_ENTRIES_D;
      end else begin
        return 0;
      end
    end
    n = mag_fill[c][ld];
    for (int i = n; i > 0; i--) begin
      if (mag_pfn[c][ld][i-1] <= lim) begin
        pfn = mag_pfn[c][ld][i-1];
        mag_pfn[c][ld][i-1] = mag_pfn[c][ld][n-1];
        mag_fill[c][ld] = n - 1;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic lookup_beat_t predict_lookup(logic func, logic [PAGES_W-1:0] pages,
                                                  logic [FIELD_W-1:0] pfn,
                                                  logic [FIELD_W-1:0] lim);
    lookup_beat_t r;
    int unsigned  c;
    logic [FIELD_W-1:0] got;
    r = '0;
    got = '0;
    c = page_class(pages);
    if (c < SIZE_CLASSES_D) begin
      if (func == FUNC_INSERT) r.ok = cache_insert(c, pfn);
      else if (lim >= FIELD_W'(pages)) r.ok = cache_fetch(c, lim - FIELD_W'(pages), got);
    end
    if (r.ok && func == FUNC_GET) r.pfn = got;
    return r;
  endfunction

  always @(posedge clk_i) begin
    lookup_beat_t e;
    if (rst_ni) begin
      if (done_i) begin
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat: ok=%0d pfn=%h", ok_i, found_pfn_i);
        end else begin
          e = expected_beats.pop_front();
          if (e.ok !== ok_i || e.pfn !== found_pfn_i) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at %0t: expected ok=%0d pfn=%h, got ok=%0d pfn=%h",
                       $realtime, e.ok, e.pfn, ok_i, found_pfn_i);
          end
        end
      end
      if (start_i && !busy_i)
        expected_beats.push_back(predict_lookup(func_i, pages_i, start_pfn_i,
                                                limit_excl_i));
    end
  end

endmodule

### tb/size_class_magazine_cache_core_test.sv
`timescale 1ns / 1ps

module size_class_magazine_cache_core_test;
  import scmc_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               func_i;
  logic [PAGES_W-1:0] pages_i;
  logic [FIELD_W-1:0] start_pfn_i;
  logic [FIELD_W-1:0] limit_excl_i;
  logic               done_o;
  logic               ok_o;
  logic [FIELD_W-1:0] found_pfn_o;
  int                 mismatches;
  int                 pending;
  int                 cycles;
  int                 issued;
  bit                 calm;

  size_class_magazine_cache_core dut (
    .clk_i, .rst_ni, .start, .busy, .func_i, .pages_i, .start_pfn_i, .limit_excl_i,
    .done_o, .ok_o, .found_pfn_o
  );

  size_class_magazine_cache_checker checker_i (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .func_i, .pages_i, .start_pfn_i,
    .limit_excl_i, .done_i(done_o), .ok_i(ok_o), .found_pfn_i(found_pfn_o),
    .mismatches_o(mismatches), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [FIELD_W-1:0] rand_wide();
    return FIELD_W'({$urandom, $urandom});
  endfunction

  function automatic logic [PAGES_W-1:0] pages_of(int cls);
    if (cls == 0) return PAGES_W'($urandom_range(0, 1));
    if (cls >= SIZE_CLASSES_D) return PAGES_W'($urandom_range(33, 65535));
    return PAGES_W'($urandom_range((1 << (cls - 1)) + 1, 1 << cls));
  endfunction

  function automatic logic [FIELD_W-1:0] rand_pfn();
    return ($urandom_range(0, 1) == 0) ? FIELD_W'($urandom_range(0, 4000)) : rand_wide();
  endfunction

  function automatic logic [FIELD_W-1:0] rand_limit();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return '1;
    if (r < 8) return rand_wide();
    return FIELD_W'($urandom_range(0, 4096));
  endfunction

  task automatic send_beat(logic func, logic [PAGES_W-1:0] pages,
                           logic [FIELD_W-1:0] pfn, logic [FIELD_W-1:0] lim);
    start        <= 1'b1;
    func_i       <= func;
    pages_i      <= pages;
    start_pfn_i  <= pfn;
    limit_excl_i <= lim;
    do @(posedge clk_i); while (busy);
    issued++;
    calm = (issued % 1000) >= 600 && (issued % 1000) < 800;
    if (!calm && $urandom_range(0, 99) < 16) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  initial begin
    int cls;
    cycles       = 0;
    issued       = 0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    func_i       = FUNC_GET;
    pages_i      = '0;
    start_pfn_i  = '0;
    limit_excl_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(FUNC_GET, 16'd1, '0, '1);
    send_beat(FUNC_INSERT, 16'd0, '0, '0);
    send_beat(FUNC_INSERT, 16'd1, '1, '0);
    send_beat(FUNC_INSERT, 16'd32, 52'h5_5555_5555_5555, '1);
    send_beat(FUNC_INSERT, 16'd33, 52'h1234, '0);
    send_beat(FUNC_INSERT, 16'hFFFF, 52'h1234, '1);
    send_beat(FUNC_GET, 16'd33, '0, '1);
    send_beat(FUNC_GET, 16'hFFFF, '1, '1);
    send_beat(FUNC_GET, 16'd1, '0, '0);
    send_beat(FUNC_GET, 16'd0, '1, '0);
    send_beat(FUNC_GET, 16'd1, '0, '1);
    send_beat(FUNC_GET, 16'd1, '0, '1);
    send_beat(FUNC_GET, 16'd32, '0, 52'd31);
    send_beat(FUNC_GET, 16'd32, '0, '1);
    send_beat(FUNC_INSERT, 16'd2, 52'hA_AAAA_AAAA_AAAA, '0);
    send_beat(FUNC_GET, 16'd2, '0, 52'h100);
    send_beat(FUNC_GET, 16'd2, '0, '1);

    // push one class through loaded and previous into the depot
    for (int i = 0; i < 400; i++) send_beat(FUNC_INSERT, pages_of(2), rand_pfn(), rand_limit());

    for (int i = 0; i < 140; i++) begin
      cls = ($urandom_range(0, 9) == 0) ? SIZE_CLASSES_D : $urandom_range(0, 5);
      if (cls > 2 && $urandom_range(0, 1)) cls = $urandom_range(0, 2);
      send_beat(1'($urandom_range(0, 1)), pages_of(cls), rand_pfn(), rand_limit());
    end

    // drain the deep class to pull magazines back off the depot
    for (int i = 0; i < 200; i++) send_beat(FUNC_GET, pages_of(2), rand_pfn(), rand_limit());

    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/scmc_pkg.sv
rtl/scmc_ram.sv
rtl/size_class_magazine_cache_core.sv
tb/size_class_magazine_cache_checker.sv
tb/size_class_magazine_cache_core_test.sv
